>>> rtl/core/ltev_pkg.sv
// Shared constants for the LRU age tile evictor.
package ltev_pkg;

  localparam int TILE_W  = 6;   // tile id width
  localparam int CNT_W   = 7;   // tile count width
  localparam int TIME_W  = 32;  // millisecond time width
  localparam int FRAME_W = 32;  // frame number width

  // Register reset values
  localparam logic [CNT_W-1:0]  MAX_TILES_RST = 7'd50;
  localparam logic [TIME_W-1:0] MAX_AGE_RST   = 32'd5000;

  // Configuration register indexes
  localparam logic CFG_MAX_TILES = 1'b0;
  localparam logic CFG_MAX_AGE   = 1'b1;

  // Request kinds
  localparam logic REQ_TOUCH  = 1'b0;
  localparam logic REQ_EXPIRE = 1'b1;

endpackage

>>> rtl/core/lru_age_tile_evictor.sv
// Top level: LRU tile order with frame-based age eviction, walked by a small sequencer.
//
//  channel | dir | handshake          | contents
//  in_     | in  | tvalid/tready      | tuser req_type, tdata tile/time/frame
//  out_    | out | tvalid/tready      | tdata evicted_tile, tlast on final eviction
//  cfg_    | in  | we (no wait)       | addr register index, wdata value
//
// A touch of a new tile goes straight to append; a resident one takes link read, unlink, append.
// An expire reads and then checks each walked tile in turn, and flushes a held eviction at the end; the walk
// is bounded by the tiles resident at the previous expire, and a stale expire returns to idle at once.
// The single read port on the link memories is why each walked tile is read before it is checked.
// Reset is synchronous; no clearing pass is needed. A full output register stalls the walk
// only when a second eviction is ready, one result being held back to mark the last one.
module lru_age_tile_evictor #(
  parameter int TILE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [5:0] tile_id, [37:6] frame_time, [69:38] frame_number
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] evicted_tile
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(TILE_SLOTS);
  localparam int TW = ltev_pkg::TILE_W;
  localparam int CW = ltev_pkg::CNT_W;
  localparam int MW = ltev_pkg::TIME_W;
  localparam int FW = ltev_pkg::FRAME_W;
  localparam logic [TW:0] SLOTS_C = (TW+1)'(TILE_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_T_RD, S_T_UNL, S_T_APP, S_E_RD, S_E_CHK, S_E_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           max_tiles_r;
  logic [MW-1:0]           max_age_r;
  logic [TW-1:0]           tile_r, tile_nxt;
  logic [MW-1:0]           now_r, now_nxt;
  logic [FW-1:0]           frame_r, frame_nxt;
  logic [TW-1:0]           head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [CW-1:0]           count_r, count_nxt, bound_r, bound_nxt, rem_r, rem_nxt;
  logic [FW-1:0]           last_frame_r, last_frame_nxt;
  logic [TILE_SLOTS-1:0]   res_r, res_nxt, old_r, old_nxt;
  logic [TW-1:0]           pend_r, pend_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TW-1:0]           out_tile_r, out_tile_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    do_unlink;
  logic [TW-1:0]           node;
  logic [IW-1:0]           rd_addr;
  logic [TW-1:0]           next_q, prev_q;
  logic [MW-1:0]           time_q;
  logic                    aged;
  logic                    nl_we, pl_we, tm_we;
  logic [IW-1:0]           nl_waddr, pl_waddr;
  logic [TW-1:0]           nl_wdata, pl_wdata;
  logic [CW-1:0]           cnt_dec;

  // Link and time memories share one read address
  assign rd_addr = (state_r == S_T_RD || state_r == S_T_UNL) ? tile_r[IW-1:0] : cur_r[IW-1:0];
  assign node    = (state_r == S_E_CHK) ? cur_r : tile_r;

  ltev_ram #(.DEPTH(TILE_SLOTS), .WIDTH(TW)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(rd_addr), .rdata(next_q)
  );

  ltev_ram #(.DEPTH(TILE_SLOTS), .WIDTH(TW)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(rd_addr), .rdata(prev_q)
  );

  ltev_ram #(.DEPTH(TILE_SLOTS), .WIDTH(MW)) u_time (
    .clk(clk), .we(tm_we), .waddr(tile_r[IW-1:0]), .wdata(now_r),
    .raddr(rd_addr), .rdata(time_q)
  );

  ltev_age u_age (
    .now(now_r), .touched(time_q), .max_age(max_age_r), .expired(aged)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tile_r};
  assign out_tlast  = out_last_r;
  assign cnt_dec    = (count_r != '0) ? count_r - CW'(1) : count_r;

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    tile_nxt       = tile_r;
    now_nxt        = now_r;
    frame_nxt      = frame_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_nxt        = cur_r;
    count_nxt      = count_r;
    bound_nxt      = bound_r;
    rem_nxt        = rem_r;
    last_frame_nxt = last_frame_r;
    res_nxt        = res_r;
    old_nxt        = old_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    out_tile_nxt   = out_tile_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r;
    do_unlink      = 1'b0;
    nl_we          = 1'b0;
    pl_we          = 1'b0;
    tm_we          = 1'b0;
    nl_waddr       = prev_q[IW-1:0];
    nl_wdata       = next_q;
    pl_waddr       = next_q[IW-1:0];
    pl_wdata       = prev_q;

    // Output register drains on its own handshake
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tile_nxt  = in_tdata[5:0];
          now_nxt   = in_tdata[37:6];
          frame_nxt = in_tdata[69:38];
          if (in_tuser == ltev_pkg::REQ_EXPIRE) begin
            if (in_tdata[69:38] > last_frame_r) begin
              cur_nxt   = head_r;
              rem_nxt   = bound_r;
              state_nxt = S_E_RD;
            end
          end else if ({1'b0, in_tdata[5:0]} < SLOTS_C) begin
            state_nxt = res_r[in_tdata[IW-1:0]] ? S_T_RD : S_T_APP;
          end
        end
      end
      S_T_RD: begin
        state_nxt = S_T_UNL;
      end
      S_T_UNL: begin
        do_unlink = 1'b1;
        state_nxt = S_T_APP;
      end
      S_T_APP: begin
        // Append at the tail and stamp the time
        nl_we    = (count_r != '0);
        nl_waddr = tail_r[IW-1:0];
        nl_wdata = tile_r;
        pl_we    = (count_r != '0);
        pl_waddr = tile_r[IW-1:0];
        pl_wdata = tail_r;
        tm_we    = 1'b1;
        if (count_r == '0) begin
          head_nxt = tile_r;
        end
        tail_nxt = tile_r;
        res_nxt[tile_r[IW-1:0]] = 1'b1;
        old_nxt[tile_r[IW-1:0]] = 1'b0;
        count_nxt = count_r + CW'(1);
        state_nxt = S_IDLE;
      end
      S_E_RD: begin
        state_nxt = (count_r > max_tiles_r && rem_r != '0) ? S_E_CHK : S_E_FLUSH;
      end
      S_E_CHK: begin
        if (!(aged && pend_v_r && out_valid_r)) begin
          rem_nxt = rem_r - CW'(1);
          cur_nxt = next_q;
          if (aged) begin
            do_unlink = 1'b1;
            if (pend_v_r) begin
              out_tile_nxt  = pend_r;
              out_last_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            pend_nxt   = cur_r;
            pend_v_nxt = 1'b1;
          end
          state_nxt = S_E_RD;
        end
      end
      S_E_FLUSH: begin
        if (pend_v_r) begin
          // Held eviction goes out marked last
          if (!out_valid_r) begin
            out_tile_nxt  = pend_r;
            out_last_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
            pend_v_nxt    = 1'b0;
          end
        end else begin
          old_nxt        = res_r;
          bound_nxt      = count_r;
          last_frame_nxt = frame_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Unlink node from the order, using its links read from memory
    if (do_unlink) begin
      nl_we = (node != head_r);
      pl_we = (node != tail_r);
      if (node == head_r) begin
        head_nxt = next_q;
      end
      if (node == tail_r) begin
        tail_nxt = prev_q;
      end
      res_nxt[node[IW-1:0]] = 1'b0;
      if (old_r[node[IW-1:0]] && bound_r != '0) begin
        bound_nxt = bound_r - CW'(1);
      end
      old_nxt[node[IW-1:0]] = 1'b0;
      count_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end
  end

  // State, registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_tiles_r  <= ltev_pkg::MAX_TILES_RST;
      max_age_r    <= ltev_pkg::MAX_AGE_RST;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      bound_r      <= '0;
      last_frame_r <= '0;
      res_r        <= '0;
      old_r        <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      bound_r      <= bound_nxt;
      last_frame_r <= last_frame_nxt;
      res_r        <= res_nxt;
      old_r        <= old_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ltev_pkg::CFG_MAX_TILES: max_tiles_r <= cfg_wdata[CW-1:0];
          default:                 max_age_r   <= cfg_wdata;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tile_r     <= tile_nxt;
    now_r      <= now_nxt;
    frame_r    <= frame_nxt;
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    pend_r     <= pend_nxt;
    out_tile_r <= out_tile_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> rtl/core/ltev_ram.sv
// Simple one-write one-read memory with registered read data.
module ltev_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ltev_age.sv
// Age check: a tile is old enough when now - touch time >= max age, never if time ran back.
module ltev_age (
  input  logic [ltev_pkg::TIME_W-1:0] now,
  input  logic [ltev_pkg::TIME_W-1:0] touched,
  input  logic [ltev_pkg::TIME_W-1:0] max_age,
  output logic                        expired
);

  logic [ltev_pkg::TIME_W:0] diff;

  // One wide subtract; the borrow bit flags negative age
  assign diff    = {1'b0, now} - {1'b0, touched};
  assign expired = !diff[ltev_pkg::TIME_W] && (diff[ltev_pkg::TIME_W-1:0] >= max_age);

endmodule

>>> sim/lru_age_tile_evictor_tb.sv
// Self-checking testbench for the LRU age tile evictor: touch/expire stream, eviction order.
module lru_age_tile_evictor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        req;
    logic [5:0]  tile;
    logic [31:0] now;
    logic [31:0] frame;
  } lru_req_t;

  typedef struct packed {
    logic [5:0] tile;
    logic       last;
  } evict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [31:0] cfg_wdata = '0;

  lru_age_tile_evictor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the tile order
  logic [5:0]  sh_next [64];
  logic [5:0]  sh_prev [64];
  logic        sh_res [64];
  logic        sh_old [64];
  logic [31:0] sh_time [64];
  logic [5:0]  sh_head, sh_tail;
  int          sh_bound, sh_count;
  logic [31:0] sh_last_frame;
  logic [6:0]  sh_max_tiles;
  logic [31:0] sh_max_age;

  lru_req_t pending_reqs[$];
  evict_t   expected_evictions[$];
  int       errors = 0;
  int       send_idle_pct = 10;
  int       recv_idle_pct = 50;
  bit       hold_off = 0;
  longint   cycles = 0;

  function automatic void order_remove(input logic [5:0] t);
    logic [5:0] p, n;
    p = sh_prev[t];
    n = sh_next[t];
    if (t == sh_head) sh_head = n; else sh_next[p] = n;
    if (t == sh_tail) sh_tail = p; else sh_prev[n] = p;
    sh_res[t] = 1'b0;
    if (sh_old[t] && sh_bound > 0) sh_bound--;
    sh_old[t] = 1'b0;
    if (sh_count > 0) sh_count--;
    if (sh_count == 0) begin
      sh_head = '0;
      sh_tail = '0;
    end
  endfunction

  function automatic void order_append(input logic [5:0] t);
    if (sh_count == 0) begin
      sh_head = t;
    end else begin
      sh_next[sh_tail] = t;
      sh_prev[t] = sh_tail;
    end
    sh_tail = t;
    sh_res[t] = 1'b1;
    sh_old[t] = 1'b0;
    sh_count++;
  endfunction

  // Apply one accepted request to the shadow state, queue the evictions it causes
  function automatic void predict_evictions(input lru_req_t r);
    logic [5:0] cur, node;
    int remaining, first;
    evict_t ev;
    if (r.req == ltev_pkg::REQ_TOUCH) begin
      if (sh_res[r.tile]) order_remove(r.tile);
      order_append(r.tile);
      sh_time[r.tile] = r.now;
      return;
    end
    if (r.frame <= sh_last_frame) return;
    cur = sh_head;
    remaining = sh_bound;
    first = expected_evictions.size();
    while (sh_count > sh_max_tiles && remaining > 0) begin
      node = cur;
      cur = sh_next[node];
      remaining--;
      if (r.now >= sh_time[node] && r.now - sh_time[node] >= sh_max_age) begin
        order_remove(node);
        ev = '{tile: node, last: 1'b0};
        expected_evictions.insert(expected_evictions.size(), ev);
      end
    end
    if (expected_evictions.size() > first)
      expected_evictions[expected_evictions.size()-1].last = 1'b1;
    for (int i = 0; i < 64; i++) sh_old[i] = sh_res[i];
    sh_bound = sh_count;
    sh_last_frame = r.frame;
  endfunction

  // Driver: one transaction per handshake, random gaps
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_evictions(pending_reqs.pop_front());
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].req;
          in_tdata  <= {2'b0, pending_reqs[0].frame, pending_reqs[0].now, pending_reqs[0].tile};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk) begin
    evict_t exp_e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_evictions.size() == 0) begin
          $error("unexpected eviction tile=%0d", out_tdata[5:0]);
          errors++;
        end else begin
          exp_e = expected_evictions.pop_front();
          if (out_tdata[5:0] !== exp_e.tile) begin
            $error("evicted_tile exp=%0d got=%0d", exp_e.tile, out_tdata[5:0]);
            errors++;
          end
          if (out_tlast !== exp_e.last) begin
            $error("last exp=%0d got=%0d", exp_e.last, out_tlast);
            errors++;
          end
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_evictions.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (addr == ltev_pkg::CFG_MAX_TILES) sh_max_tiles = val[6:0];
    else sh_max_age = val;
  endtask

  function automatic void add_req(input logic req, input logic [5:0] tile,
                                  input logic [31:0] now, input logic [31:0] frame);
    lru_req_t pr;
    pr = '{req: req, tile: tile, now: now, frame: frame};
    pending_reqs.insert(pending_reqs.size(), pr);
  endfunction

  logic [31:0] frame_no = 0;
  logic [31:0] clock_ms = 0;

  // Mostly well-formed frames: touches at a rising time, then an expire for the next frame
  task automatic random_frames(input int n_items, input int tile_span);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 8)) begin
        add_req(ltev_pkg::REQ_TOUCH, 6'($urandom_range(tile_span - 1)),
                ($urandom_range(19) == 0) ? $urandom : clock_ms, $urandom);
        sent++;
      end
      clock_ms = clock_ms + $urandom_range(0, 3000);
      if ($urandom_range(9) == 0) begin
        add_req(ltev_pkg::REQ_EXPIRE, 6'($urandom), clock_ms, frame_no - $urandom_range(0, 2));
      end else begin
        frame_no = frame_no + $urandom_range(1, 3);
        add_req(ltev_pkg::REQ_EXPIRE, 6'($urandom), clock_ms, frame_no);
      end
      sent++;
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      sh_next[i] = '0; sh_prev[i] = '0; sh_res[i] = 0; sh_old[i] = 0; sh_time[i] = '0;
    end
    sh_head = '0; sh_tail = '0; sh_bound = 0; sh_count = 0; sh_last_frame = '0;
    sh_max_tiles = ltev_pkg::MAX_TILES_RST;
    sh_max_age = ltev_pkg::MAX_AGE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small limits so eviction happens
    write_reg(ltev_pkg::CFG_MAX_TILES, 32'd2);
    write_reg(ltev_pkg::CFG_MAX_AGE, 32'd0);
    add_req(ltev_pkg::REQ_TOUCH, 6'd0, 32'd100, 32'd0);
    add_req(ltev_pkg::REQ_TOUCH, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(ltev_pkg::REQ_TOUCH, 6'd5, 32'd0, 32'd0);
    add_req(ltev_pkg::REQ_TOUCH, 6'd0, 32'd200, 32'd0);
    add_req(ltev_pkg::REQ_EXPIRE, 6'd0, 32'd300, 32'd1);   // boundary set, nothing old yet
    add_req(ltev_pkg::REQ_EXPIRE, 6'd63, 32'd300, 32'd1);  // stale frame
    add_req(ltev_pkg::REQ_TOUCH, 6'd7, 32'd300, 32'd0);
    add_req(ltev_pkg::REQ_EXPIRE, 6'd0, 32'd300, 32'd2);   // time backwards for tile 63
    add_req(ltev_pkg::REQ_EXPIRE, 6'd0, 32'hFFFF_FFFF, 32'd3);
    add_req(ltev_pkg::REQ_TOUCH, 6'd63, 32'd10, 32'd0);
    add_req(ltev_pkg::REQ_TOUCH, 6'd63, 32'd20, 32'd0);    // touch of the tile already at the tail
    add_req(ltev_pkg::REQ_EXPIRE, 6'd0, 32'd0, 32'd0);
    frame_no = 32'd3;
    wait_drained();

    // Large limits: no eviction, order churn only
    send_idle_pct = 10; recv_idle_pct = 50;
    write_reg(ltev_pkg::CFG_MAX_TILES, 32'd64);
    write_reg(ltev_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
    random_frames(10, 64);
    wait_drained();

    // Few tile ids, tight count limit and a moderate age
    frame_no = sh_last_frame;
    send_idle_pct = 50; recv_idle_pct = 10;
    write_reg(ltev_pkg::CFG_MAX_TILES, 32'd0);
    write_reg(ltev_pkg::CFG_MAX_AGE, 32'd1000);
    random_frames(40, 16);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(ltev_pkg::CFG_MAX_TILES, 32'd3);
    write_reg(ltev_pkg::CFG_MAX_AGE, 32'd0);
    hold_off = 1;
    random_frames(30, 64);
    repeat (400) @(posedge clk);
    hold_off = 0;
    wait_drained();

    write_reg(ltev_pkg::CFG_MAX_TILES, 32'd50);
    write_reg(ltev_pkg::CFG_MAX_AGE, 32'd5000);
    random_frames(40, 64);
    wait_drained();

    if (errors == 0 && expected_evictions.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
